>>> rtl/ptp_pkg.sv
// ptp_pkg: types, widths and constants of the planar texture coordinate projection
// used by ptp_sqrt_cell, ptp_div_cell and planar_texcoord_projection
// no dependencies
package ptp_pkg;

    // unit vectors carry 1.0 as 2^UNIT_BITS, coordinates are divided by 2^UV_SHIFT
    localparam int UNIT_BITS  = 29;
    localparam int UV_SHIFT   = 3;

    // differences, cross products and axis vectors
    localparam int D_W        = 33;
    localparam int PROD_W     = 49;
    localparam int VEC_W      = 50;
    localparam int MAG_W      = VEC_W - 1;

    // leading one search in groups
    localparam int GRP_W      = 7;
    localparam int N_GRP      = MAG_W / GRP_W;
    localparam int GPOS_W     = 3;
    localparam int POS_W      = 6;

    // normalized magnitudes, squares and their sum
    localparam int SMAG_W     = UNIT_BITS + 1;
    localparam int SQ_W       = 2 * SMAG_W;
    localparam int SUM_W      = SQ_W + 2;

    // square root cells
    localparam int ROOT_W     = SUM_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQRT_STEPS = SUM_W / 2;

    // divider cells
    localparam int QUO_W      = UNIT_BITS + 1;
    localparam int DREM_W     = ROOT_W + 1;
    localparam int DIV_STEPS  = QUO_W;

    // projection
    localparam int UNIT_W     = QUO_W + 1;
    localparam int DPROD_W    = 64;
    localparam int DOT_W      = 66;
    localparam int SH_W       = DOT_W - UNIT_BITS - UV_SHIFT;
    localparam int OUT_W      = 32;

    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // axis lanes
    localparam int AX_U = 0;
    localparam int AX_V = 1;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] edge_end_x;
        logic signed [31:0] edge_end_y;
        logic signed [31:0] edge_end_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic               axes_ok;
    } t_out_item;

    // what travels beside the axis math: point offset, axis signs, length flag
    typedef struct packed {
        logic signed [D_W-1:0] d_x;
        logic signed [D_W-1:0] d_y;
        logic signed [D_W-1:0] d_z;
        logic [1:0][2:0]       neg;
        logic                  ok;
    } t_side;

    // through the square root chain the normalized magnitudes ride along
    typedef struct packed {
        t_side                         side;
        logic [1:0][2:0][SMAG_W-1:0]   mag;
    } t_sq_pay;

endpackage

>>> rtl/planar_texcoord_projection.sv
// planar_texcoord_projection: top level, front end, cell chains and projection
// depends on ptp_pkg, ptp_sqrt_cell, ptp_div_cell
//
// Usage
//   Input channel i_in_valid / o_in_ready carries one vertex job (t_in_item): plane
//   normal, first and second face vertex, and the vertex to map. Output channel
//   o_out_valid / i_out_ready carries t_out_item: tex_u, tex_v (Q16.16) and axes_ok.
//   A transfer happens on a rising edge with valid and ready both high.
//   Pipeline: a job passes in order through 9 front stages (differences, cross
//   product, leading one search, normalize, squares, sum), 31 square root cells,
//   30 divider cells, 3 projection stages and the output register, which drives
//   o_out_valid.
//   Throughput: one item per cycle; each cell finishes one digit and hands it on,
//   so a new job enters every cycle while the receiver takes results.
//   Stall: the whole pipeline holds while a result waits in the output register and
//   i_out_ready is low; o_in_ready is low exactly then. No item is lost or dropped.
//   Reset (i_rst_n low, synchronous): all stage valid bits clear, no result shows.
//   When an axis has zero length the result is 0, 0 with axes_ok low.
module planar_texcoord_projection import ptp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic w_en;

    logic signed [15:0] w_in_n [3];
    logic signed [31:0] w_in_o [3];
    logic signed [31:0] w_in_e [3];
    logic signed [31:0] w_in_p [3];

    // front stage registers
    logic                    r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9;
    logic signed [15:0]      r1_n [3];
    logic signed [D_W-1:0]   r1_e [3];
    logic signed [D_W-1:0]   r1_d [3];
    logic signed [PROD_W-1:0] r2_pa [3];
    logic signed [PROD_W-1:0] r2_pb [3];
    logic signed [D_W-1:0]   r2_e [3];
    logic signed [D_W-1:0]   r2_d [3];
    logic signed [VEC_W-1:0] r3_vec [2][3];
    t_side                   r3_side, r4_side, r5_side, r6_side, r7_side, r8_side, r9_side;
    logic [MAG_W-1:0]        r4_mag [2][3];
    logic [MAG_W-1:0]        r4_or [2];
    logic [MAG_W-1:0]        r5_mag [2][3];
    logic                    r5_gnz [2][N_GRP];
    logic [GPOS_W-1:0]       r5_gpos [2][N_GRP];
    logic [MAG_W-1:0]        r6_mag [2][3];
    logic [POS_W-1:0]        r6_pos [2];
    logic [1:0]              r6_nz;
    logic [SMAG_W-1:0]       r7_smag [2][3];
    logic [SMAG_W-1:0]       r8_smag [2][3];
    logic [SQ_W-1:0]         r8_sq [2][3];
    logic [1:0][2:0][SMAG_W-1:0] r9_smag;
    logic [1:0][SUM_W-1:0]   r9_sum;

    // front stage combinational values
    logic [1:0][2:0]         w_neg;
    logic [MAG_W-1:0]        w_mag [2][3];
    logic [VEC_W-1:0]        w_abs [2][3];
    logic                    w_gnz [2][N_GRP];
    logic [GPOS_W-1:0]       w_gpos [2][N_GRP];
    logic [POS_W-1:0]        w_pos [2];
    logic [1:0]              w_nz;
    logic [MAG_W-1:0]        w_shifted [2][3];

    // projection stage registers
    logic                    r_pv1, r_pv2, r_pv3;
    t_side                   r_p1_side, r_p2_side, r_p3_side;
    logic signed [UNIT_W-1:0]  r_p1_unit [2][3];
    logic signed [DPROD_W-1:0] r_p2_prod [2][3];
    logic signed [DOT_W-1:0]   r_p3_dot [2];
    logic signed [D_W-1:0]   w_d [3];
    logic signed [SH_W-1:0]  w_sh [2];
    logic [OUT_W-1:0]        w_sat [2];

    // output register
    logic                    r_out_valid;
    t_out_item               r_out_item;
    t_out_item               n_out_item;

    // cell chain links
    logic                              sq_valid [SQRT_STEPS+1];
    t_sq_pay                           sq_pay   [SQRT_STEPS+1];
    logic [1:0][SUM_W-1:0]             sq_rad   [SQRT_STEPS+1];
    logic [1:0][REM_W-1:0]             sq_rem   [SQRT_STEPS+1];
    logic [1:0][ROOT_W-1:0]            sq_root  [SQRT_STEPS+1];
    logic                              dv_valid [DIV_STEPS+1];
    t_side                             dv_side  [DIV_STEPS+1];
    logic [1:0][ROOT_W-1:0]            dv_len   [DIV_STEPS+1];
    logic [1:0][2:0][DREM_W-1:0]       dv_r     [DIV_STEPS+1];
    logic [1:0][2:0][QUO_W-1:0]        dv_q     [DIV_STEPS+1];

    // pipeline advances unless a result is held in the output register and i_out_ready is low
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    assign w_in_n[0] = i_in_item.normal_x;
    assign w_in_n[1] = i_in_item.normal_y;
    assign w_in_n[2] = i_in_item.normal_z;
    assign w_in_o[0] = i_in_item.origin_x;
    assign w_in_o[1] = i_in_item.origin_y;
    assign w_in_o[2] = i_in_item.origin_z;
    assign w_in_e[0] = i_in_item.edge_end_x;
    assign w_in_e[1] = i_in_item.edge_end_y;
    assign w_in_e[2] = i_in_item.edge_end_z;
    assign w_in_p[0] = i_in_item.point_x;
    assign w_in_p[1] = i_in_item.point_y;
    assign w_in_p[2] = i_in_item.point_z;

    // valid bits of front and projection stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
            r_pv1 <= 1'b0;
            r_pv2 <= 1'b0;
            r_pv3 <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
            r_pv1 <= dv_valid[DIV_STEPS];
            r_pv2 <= r_pv1;
            r_pv3 <= r_pv2;
            r_out_valid <= r_pv3;
        end
    end

    // stage 1: edge and point offsets from the first vertex
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r1_n[c] <= w_in_n[c];
                r1_e[c] <= {w_in_e[c][31], w_in_e[c]} - {w_in_o[c][31], w_in_o[c]};
                r1_d[c] <= {w_in_p[c][31], w_in_p[c]} - {w_in_o[c][31], w_in_o[c]};
            end
        end
    end

    // stage 2: cross product terms of normal and edge
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pa[0] <= r1_n[1] * r1_e[2];
            r2_pb[0] <= r1_n[2] * r1_e[1];
            r2_pa[1] <= r1_n[2] * r1_e[0];
            r2_pb[1] <= r1_n[0] * r1_e[2];
            r2_pa[2] <= r1_n[0] * r1_e[1];
            r2_pb[2] <= r1_n[1] * r1_e[0];
            r2_e <= r1_e;
            r2_d <= r1_d;
        end
    end

    // stage 3: u axis is the edge, v axis is normal cross edge
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r3_vec[AX_U][c] <= VEC_W'(r2_e[c]);
                r3_vec[AX_V][c] <= r2_pa[c] - r2_pb[c];
            end
            r3_side.d_x <= r2_d[0];
            r3_side.d_y <= r2_d[1];
            r3_side.d_z <= r2_d[2];
            r3_side.neg <= '0;
            r3_side.ok  <= 1'b0;
        end
    end

    // stage 4: magnitudes, signs and the or of the magnitudes
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int c = 0; c < 3; c++) begin
                w_neg[a][c] = r3_vec[a][c][VEC_W-1];
                w_abs[a][c] = w_neg[a][c] ? -r3_vec[a][c] : r3_vec[a][c];
                w_mag[a][c] = w_abs[a][c][MAG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_mag <= w_mag;
            for (int a = 0; a < 2; a++) begin
                r4_or[a] <= w_mag[a][0] | w_mag[a][1] | w_mag[a][2];
            end
            r4_side <= {r3_side.d_x, r3_side.d_y, r3_side.d_z, w_neg, r3_side.ok};
        end
    end

    // stage 5: leading one inside each bit group
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int g = 0; g < N_GRP; g++) begin
                w_gnz[a][g]  = |r4_or[a][g*GRP_W +: GRP_W];
                w_gpos[a][g] = '0;
                for (int b = 0; b < GRP_W; b++) begin
                    if (r4_or[a][g*GRP_W + b]) begin
                        w_gpos[a][g] = GPOS_W'(b);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_mag  <= r4_mag;
            r5_gnz  <= w_gnz;
            r5_gpos <= w_gpos;
            r5_side <= r4_side;
        end
    end

    // stage 6: highest nonempty group gives the leading one position
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_pos[a] = '0;
            w_nz[a]  = 1'b0;
            for (int g = 0; g < N_GRP; g++) begin
                if (r5_gnz[a][g]) begin
                    w_pos[a] = POS_W'(g * GRP_W) + POS_W'(r5_gpos[a][g]);
                    w_nz[a]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_mag  <= r5_mag;
            r6_pos  <= w_pos;
            r6_nz   <= w_nz;
            r6_side <= r5_side;
        end
    end

    // stage 7: shift so the largest magnitude has its top bit at UNIT_BITS
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int c = 0; c < 3; c++) begin
                if (r6_pos[a] >= POS_W'(UNIT_BITS)) begin
                    w_shifted[a][c] = r6_mag[a][c] >> (r6_pos[a] - POS_W'(UNIT_BITS));
                end else begin
                    w_shifted[a][c] = r6_mag[a][c] << (POS_W'(UNIT_BITS) - r6_pos[a]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 2; a++) begin
                for (int c = 0; c < 3; c++) begin
                    r7_smag[a][c] <= w_shifted[a][c][SMAG_W-1:0];
                end
            end
            r7_side <= {r6_side.d_x, r6_side.d_y, r6_side.d_z, r6_side.neg,
                        r6_nz[AX_U] & r6_nz[AX_V]};
        end
    end

    // stage 8: squares
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 2; a++) begin
                for (int c = 0; c < 3; c++) begin
                    r8_sq[a][c] <= r7_smag[a][c] * r7_smag[a][c];
                end
            end
            r8_smag <= r7_smag;
            r8_side <= r7_side;
        end
    end

    // stage 9: sum of squares
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 2; a++) begin
                r9_sum[a] <= SUM_W'(r8_sq[a][0]) + SUM_W'(r8_sq[a][1])
                           + SUM_W'(r8_sq[a][2]);
                for (int c = 0; c < 3; c++) begin
                    r9_smag[a][c] <= r8_smag[a][c];
                end
            end
            r9_side <= r8_side;
        end
    end

    // square root chain
    assign sq_valid[0]      = r_v9;
    assign sq_pay[0].side   = r9_side;
    assign sq_pay[0].mag    = r9_smag;
    assign sq_rad[0]        = r9_sum;
    assign sq_rem[0]        = '0;
    assign sq_root[0]       = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        ptp_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (sq_valid[k]),
            .i_pay   (sq_pay[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .o_valid (sq_valid[k+1]),
            .o_pay   (sq_pay[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1])
        );
    end

    // divider chain, each lane starts from its normalized magnitude
    assign dv_valid[0] = sq_valid[SQRT_STEPS];
    assign dv_side[0]  = sq_pay[SQRT_STEPS].side;
    assign dv_len[0]   = sq_root[SQRT_STEPS];
    assign dv_q[0]     = '0;

    for (genvar a = 0; a < 2; a++) begin : g_dv_axis
        for (genvar c = 0; c < 3; c++) begin : g_dv_lane
            assign dv_r[0][a][c] = DREM_W'(sq_pay[SQRT_STEPS].mag[a][c]);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        ptp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (dv_valid[k]),
            .i_side  (dv_side[k]),
            .i_len   (dv_len[k]),
            .i_r     (dv_r[k]),
            .i_q     (dv_q[k]),
            .o_valid (dv_valid[k+1]),
            .o_side  (dv_side[k+1]),
            .o_len   (dv_len[k+1]),
            .o_r     (dv_r[k+1]),
            .o_q     (dv_q[k+1])
        );
    end

    // projection 1: signed unit components
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 2; a++) begin
                for (int c = 0; c < 3; c++) begin
                    if (dv_side[DIV_STEPS].neg[a][c]) begin
                        r_p1_unit[a][c] <= -$signed({1'b0, dv_q[DIV_STEPS][a][c]});
                    end else begin
                        r_p1_unit[a][c] <= $signed({1'b0, dv_q[DIV_STEPS][a][c]});
                    end
                end
            end
            r_p1_side <= dv_side[DIV_STEPS];
        end
    end

    // projection 2: offset times unit axis, per component
    assign w_d[0] = r_p1_side.d_x;
    assign w_d[1] = r_p1_side.d_y;
    assign w_d[2] = r_p1_side.d_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 2; a++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p2_prod[a][c] <= w_d[c] * r_p1_unit[a][c];
                end
            end
            r_p2_side <= r_p1_side;
        end
    end

    // projection 3: dot products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 2; a++) begin
                r_p3_dot[a] <= DOT_W'(r_p2_prod[a][0]) + DOT_W'(r_p2_prod[a][1])
                             + DOT_W'(r_p2_prod[a][2]);
            end
            r_p3_side <= r_p2_side;
        end
    end

    // floor shift by unit scale and the divide by eight, then saturate
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_sh[a] = r_p3_dot[a][DOT_W-1 -: SH_W];
            if ((&w_sh[a][SH_W-1:OUT_W-1]) || !(|w_sh[a][SH_W-1:OUT_W-1])) begin
                w_sat[a] = w_sh[a][OUT_W-1:0];
            end else if (w_sh[a][SH_W-1]) begin
                w_sat[a] = SAT_MIN;
            end else begin
                w_sat[a] = SAT_MAX;
            end
        end
        n_out_item.axes_ok = r_p3_side.ok;
        n_out_item.tex_u   = r_p3_side.ok ? w_sat[AX_U] : '0;
        n_out_item.tex_v   = r_p3_side.ok ? w_sat[AX_V] : '0;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a zero-length axis gives a zero coordinate pair
    a_zero_on_bad_axes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.axes_ok) |->
            (o_out_item.tex_u == '0 && o_out_item.tex_v == '0))
        else $error("coordinates not cleared for a zero-length axis");

    // input is held back only by a result waiting on a stalled receiver
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a held result");

    // with unit axes the projected coordinate always fits 32 bits
    a_no_saturation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv3 && r_p3_side.ok) |->
            ((&w_sh[AX_U][SH_W-1:OUT_W-1]) || !(|w_sh[AX_U][SH_W-1:OUT_W-1])) &&
            ((&w_sh[AX_V][SH_W-1:OUT_W-1]) || !(|w_sh[AX_V][SH_W-1:OUT_W-1])))
        else $error("projection out of range, axis scale is wrong");

endmodule

>>> rtl/ptp_sqrt_cell.sv
// ptp_sqrt_cell: one digit step of the integer square root, both axes side by side
// depends on ptp_pkg
module ptp_sqrt_cell import ptp_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  t_sq_pay                      i_pay,
    input  logic [1:0][SUM_W-1:0]        i_rad,
    input  logic [1:0][REM_W-1:0]        i_rem,
    input  logic [1:0][ROOT_W-1:0]       i_root,
    output logic                         o_valid,
    output t_sq_pay                      o_pay,
    output logic [1:0][SUM_W-1:0]        o_rad,
    output logic [1:0][REM_W-1:0]        o_rem,
    output logic [1:0][ROOT_W-1:0]       o_root
);

    logic                          r_valid;
    t_sq_pay                       r_pay;
    logic [1:0][SUM_W-1:0]         r_rad;
    logic [1:0][REM_W-1:0]         r_rem;
    logic [1:0][ROOT_W-1:0]        r_root;

    logic [1:0][SUM_W-1:0]         n_rad;
    logic [1:0][REM_W-1:0]         n_rem;
    logic [1:0][ROOT_W-1:0]        n_root;
    logic [1:0][REM_W+1:0]         w_acc;
    logic [1:0][REM_W+1:0]         w_trial;
    logic [1:0][REM_W+1:0]         w_diff;
    logic [1:0]                    w_ge;

    // bring down two radicand bits, try subtracting 4*root+1
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_acc[a]   = {i_rem[a], i_rad[a][SUM_W-1 -: 2]};
            w_trial[a] = {2'b00, i_root[a], 2'b01};
            w_diff[a]  = w_acc[a] - w_trial[a];
            w_ge[a]    = (w_acc[a] >= w_trial[a]);
            n_rem[a]   = w_ge[a] ? w_diff[a][REM_W-1:0] : w_acc[a][REM_W-1:0];
            n_root[a]  = {i_root[a][ROOT_W-2:0], w_ge[a]};
            n_rad[a]   = {i_rad[a][SUM_W-3:0], 2'b00};
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pay  <= i_pay;
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_pay   = r_pay;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

>>> rtl/ptp_div_cell.sv
// ptp_div_cell: one quotient bit of the unit vector division, six lanes over two axes
// depends on ptp_pkg
module ptp_div_cell import ptp_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  t_side                          i_side,
    input  logic [1:0][ROOT_W-1:0]         i_len,
    input  logic [1:0][2:0][DREM_W-1:0]    i_r,
    input  logic [1:0][2:0][QUO_W-1:0]     i_q,
    output logic                           o_valid,
    output t_side                          o_side,
    output logic [1:0][ROOT_W-1:0]         o_len,
    output logic [1:0][2:0][DREM_W-1:0]    o_r,
    output logic [1:0][2:0][QUO_W-1:0]     o_q
);

    logic                          r_valid;
    t_side                         r_side;
    logic [1:0][ROOT_W-1:0]        r_len;
    logic [1:0][2:0][DREM_W-1:0]   r_r;
    logic [1:0][2:0][QUO_W-1:0]    r_q;

    logic [1:0][2:0][DREM_W-1:0]   n_r;
    logic [1:0][2:0][QUO_W-1:0]    n_q;
    logic [1:0][2:0][DREM_W-1:0]   w_rs;
    logic [1:0][2:0]               w_ge;

    // restoring step: compare with the length, subtract, shift
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int c = 0; c < 3; c++) begin
                w_ge[a][c] = (i_r[a][c] >= {1'b0, i_len[a]});
                w_rs[a][c] = w_ge[a][c] ? (i_r[a][c] - {1'b0, i_len[a]}) : i_r[a][c];
                n_r[a][c]  = {w_rs[a][c][DREM_W-2:0], 1'b0};
                n_q[a][c]  = {i_q[a][c][QUO_W-2:0], w_ge[a][c]};
            end
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_len  <= i_len;
            r_r    <= n_r;
            r_q    <= n_q;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_len   = r_len;
    assign o_r     = r_r;
    assign o_q     = r_q;

endmodule

>>> sim/ptp_texcoord_checker.sv
// ptp_texcoord_checker: watches both channels of planar_texcoord_projection,
// predicts texture coordinates per input transfer and compares results
// depends on ptp_pkg
`timescale 1ns / 100ps

module ptp_texcoord_checker import ptp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    // ring of predicted results, far deeper than the pipeline
    t_out_item want_buf [256];
    logic [7:0] r_wr_idx;
    logic [7:0] r_rd_idx;
    int         r_in_count;
    int         r_out_count;
    int         fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = r_in_count - r_out_count;

    // floor integer square root
    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale a vector to unit length with 1.0 as 2^29
    function automatic logic unit_axis(input longint v[3], output longint unit_v[3]);
        logic [63:0] mag[3];
        logic [63:0] top;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        top = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > top) top = mag[i];
            unit_v[i] = 0;
        end
        if (top == 0) return 1'b0;
        while (top >= (64'd1 << 30)) begin
            top = top >> 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (top < (64'd1 << 29)) begin
            top = top << 1;
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
        len = root_floor(sum);
        if (len == 0) return 1'b0;
        for (int i = 0; i < 3; i++) begin
            q = (mag[i] << UNIT_BITS) / len;
            unit_v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    // dot with unit axis, floor divide by 2^32, saturate
    function automatic logic [31:0] axis_coord(input longint d[3], input longint a[3]);
        longint dot;
        longint q;
        dot = d[0] * a[0] + d[1] * a[1] + d[2] * a[2];
        q = dot >>> (UNIT_BITS + UV_SHIFT);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic t_out_item project_vertex(input t_in_item it);
        longint    n[3], e[3], d[3], w[3], ua[3], va[3];
        t_out_item r;
        logic      ok_u, ok_v;
        n[0] = it.normal_x;
        n[1] = it.normal_y;
        n[2] = it.normal_z;
        e[0] = longint'(it.edge_end_x) - longint'(it.origin_x);
        e[1] = longint'(it.edge_end_y) - longint'(it.origin_y);
        e[2] = longint'(it.edge_end_z) - longint'(it.origin_z);
        d[0] = longint'(it.point_x) - longint'(it.origin_x);
        d[1] = longint'(it.point_y) - longint'(it.origin_y);
        d[2] = longint'(it.point_z) - longint'(it.origin_z);
        w[0] = n[1] * e[2] - n[2] * e[1];
        w[1] = n[2] * e[0] - n[0] * e[2];
        w[2] = n[0] * e[1] - n[1] * e[0];
        r = '0;
        ok_u = unit_axis(e, ua);
        ok_v = unit_axis(w, va);
        if (ok_u && ok_v) begin
            r.tex_u   = axis_coord(d, ua);
            r.tex_v   = axis_coord(d, va);
            r.axes_ok = 1'b1;
        end
        return r;
    endfunction

    // predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            fail_count  <= 0;
            r_in_count  <= 0;
            r_out_count <= 0;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                want_buf[r_wr_idx] <= project_vertex(i_in_item);
                r_wr_idx           <= r_wr_idx + 8'd1;
                r_in_count         <= r_in_count + 1;
            end
            if (i_out_valid && i_out_ready) begin
                if (r_in_count == r_out_count) begin
                    if (fail_count < 10)
                        $display("unexpected result u=%h v=%h ok=%b", i_out_item.tex_u,
                                 i_out_item.tex_v, i_out_item.axes_ok);
                    fail_count <= fail_count + 1;
                end else begin
                    want = want_buf[r_rd_idx];
                    r_rd_idx    <= r_rd_idx + 8'd1;
                    r_out_count <= r_out_count + 1;
                    if (want !== i_out_item) begin
                        if (fail_count < 10)
                            $display("mismatch: expected u=%h v=%h ok=%b got u=%h v=%h ok=%b",
                                     want.tex_u, want.tex_v, want.axes_ok, i_out_item.tex_u,
                                     i_out_item.tex_v, i_out_item.axes_ok);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> sim/tb_planar_texcoord_projection.sv
// tb_planar_texcoord_projection: stimulus, clock, reset and verdict
// depends on ptp_pkg, planar_texcoord_projection, ptp_texcoord_checker
`timescale 1ns / 100ps

module tb_planar_texcoord_projection;
    import ptp_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    logic      calm = 1'b0;

    planar_texcoord_projection dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_in_item(in_item), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_item(out_item)
    );

    ptp_texcoord_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_in_item(in_item), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_item(out_item), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("tb_planar_texcoord_projection failed");
            $finish;
        end
    end

    // receiver stalls at random except in the calm stretch
    always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 19);

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return $urandom_range(32'h0003ffff) - 32'h00020000;
        endcase
    endfunction

    function automatic logic [15:0] rand_normal();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'h8000;
            4: return 16'h0000;
            default: return 16'($urandom_range(32768) - 16384);
        endcase
    endfunction

    // one transfer, idling first at random; valid stays up between transfers
    task automatic send_vertex(input t_in_item it);
        while (!calm && $urandom_range(99) < 19) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic t_in_item face_item(input logic [15:0] nx, ny, nz,
                                           input logic [31:0] ox, oy, oz, ex, ey, ez,
                                           input logic [31:0] px, py, pz);
        t_in_item it;
        it.normal_x = nx; it.normal_y = ny; it.normal_z = nz;
        it.origin_x = ox; it.origin_y = oy; it.origin_z = oz;
        it.edge_end_x = ex; it.edge_end_y = ey; it.edge_end_z = ez;
        it.point_x = px; it.point_y = py; it.point_z = pz;
        return it;
    endfunction

    initial begin
        t_in_item it;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: plain face, zero edge, zero normal, parallel normal, extremes
        send_vertex(face_item(0, 0, 16384, 0, 0, 0, 32'h10000, 0, 0, 32'h8000, 32'h4000, 0));
        send_vertex(face_item(0, 0, 16384, 5, 6, 7, 5, 6, 7, 1, 2, 3));
        send_vertex(face_item(0, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 9, 9, 9));
        send_vertex(face_item(16384, 0, 0, 0, 0, 0, 32'h10000, 0, 0, 9, 9, 9));
        send_vertex(face_item(0, 0, 16384, 1, 2, 3, 32'h20000, 0, 0, 1, 2, 3));
        send_vertex(face_item(16'h8000, 16'h8000, 16'h7fff, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                              32'h7fffffff, 32'h80000000, 32'h7fffffff));
        send_vertex(face_item(16'h7fff, 16'h8000, 16'h0001, 32'h7fffffff, 32'h80000000,
                              32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                              32'h80000000, 32'h7fffffff, 32'h80000000));
        send_vertex(face_item(16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff,
                              32'hffffffff, 0, 0, 0, 32'hffffffff, 32'hffffffff, 0));
        send_vertex(face_item(-16384, 16384, 0, 0, 0, 0, 1, 1, 1, 32'h7fffffff,
                              32'h7fffffff, 32'h7fffffff));
        send_vertex(face_item(0, 16384, 0, 0, 0, 0, 0, 0, 1, 32'h80000000, 0, 1));

        // random: mostly valid faces, some degenerate ones
        for (int n = 0; n < 1450; n++) begin
            calm = (n >= 600 && n < 800);
            it = face_item(rand_normal(), rand_normal(), rand_normal(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord(), rand_coord());
            if ($urandom_range(19) == 0) begin
                it.edge_end_x = it.origin_x;
                it.edge_end_y = it.origin_y;
                it.edge_end_z = it.origin_z;
            end else if ($urandom_range(19) == 0) begin
                it.normal_x = it.edge_end_x[15:0] - it.origin_x[15:0];
                it.normal_y = 0;
                it.normal_z = 0;
                it.edge_end_y = it.origin_y;
                it.edge_end_z = it.origin_z;
            end
            send_vertex(it);
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb_planar_texcoord_projection passed");
        end else begin
            $display("tb_planar_texcoord_projection failed");
        end
        $finish;
    end

endmodule
